// ----- sv/csim_pkg.sv -----
// Shared types and constants for the streaming cosine similarity block.
// Used by the controller, the datapath and the top level; depends on nothing.
package csim_pkg;

    // Element and accumulator sizes.
    localparam int ELEM_WIDTH   = 16;
    localparam int PROD_WIDTH   = 2 * ELEM_WIDTH;
    localparam int ACC_WIDTH    = 48;
    localparam int ROOT_WIDTH   = ACC_WIDTH / 2;
    localparam int FRAC_BITS    = 15;
    localparam int NUM_WIDTH    = ACC_WIDTH + FRAC_BITS;
    localparam int CFG_WIDTH    = 32;
    localparam int SIM_WIDTH    = 16;
    localparam int DEF_MAX_LEN  = 1024;

    // Iteration counts of the root and divide loops.
    localparam int SQRT_STEPS   = ROOT_WIDTH;
    localparam int DIV_STEPS    = NUM_WIDTH;
    localparam int CNT_WIDTH    = $clog2(DIV_STEPS);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic acc_en;     // accumulate the accepted pair
        logic load_work;  // last pair: capture sums into work registers and clear
        logic sqrt_step;  // one step of both square roots
        logic mul_en;     // multiply the two roots
        logic div_step;   // one step of the restoring divider
        logic out_load;   // load the result register
    } csim_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic special;    // zero vector or too long: skip the arithmetic
    } csim_stat_t;

endpackage

// ----- sv/csim_ctrl.sv -----
// Controller state machine of the cosine similarity block.
// Depends on csim_pkg; drives the command struct of csim_dp.
module csim_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_last_element,
    output logic                  m_valid,
    input  logic                  m_ready,
    input  csim_pkg::csim_stat_t  stat,
    output csim_pkg::csim_cmd_t   cmd
);

    localparam logic [2:0] ST_ACCUM = 3'd0;
    localparam logic [2:0] ST_SQRT  = 3'd1;
    localparam logic [2:0] ST_MUL   = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_FIN   = 3'd4;

    localparam logic [csim_pkg::CNT_WIDTH-1:0] SQRT_LAST =
        csim_pkg::CNT_WIDTH'(csim_pkg::SQRT_STEPS - 1);
    localparam logic [csim_pkg::CNT_WIDTH-1:0] DIV_LAST =
        csim_pkg::CNT_WIDTH'(csim_pkg::DIV_STEPS - 1);

    logic [2:0]                     state_reg, state_next;
    logic [csim_pkg::CNT_WIDTH-1:0] cnt_reg, cnt_next;
    logic                           m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == ST_ACCUM);
    assign m_valid = m_valid_reg;

    // Next state, iteration counter and commands.
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_ACCUM: begin
                if (s_valid) begin
                    cmd.acc_en = 1'b1;
                    if (s_last_element) begin
                        cmd.load_work = 1'b1;
                        cnt_next      = '0;
                        state_next    = ST_SQRT;
                    end
                end
            end
            ST_SQRT: begin
                if (stat.special) begin
                    state_next = ST_FIN;
                end else begin
                    cmd.sqrt_step = 1'b1;
                    cnt_next      = cnt_reg + 1'b1;
                    if (cnt_reg == SQRT_LAST) begin
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                cmd.mul_en = 1'b1;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_ACCUM;
                end
            end
            default: state_next = ST_ACCUM;
        endcase
    end

    // Output valid holds until the result transfer completes.
    assign m_valid_next = cmd.out_load | (m_valid_reg & ~m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_ACCUM;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ----- sv/csim_dp.sv -----
// Datapath of the cosine similarity block: accumulators, roots, divider, result.
// Depends on csim_pkg; commanded by csim_ctrl.
module csim_dp #(
    parameter int MAX_LEN = csim_pkg::DEF_MAX_LEN
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [csim_pkg::CFG_WIDTH-1:0]        cfg_wr_data,
    input  logic signed [csim_pkg::ELEM_WIDTH-1:0] s_elem_a,
    input  logic signed [csim_pkg::ELEM_WIDTH-1:0] s_elem_b,
    input  csim_pkg::csim_cmd_t                   cmd,
    output csim_pkg::csim_stat_t                  stat,
    output logic signed [csim_pkg::SIM_WIDTH-1:0] m_similarity,
    output logic                                  m_zero_vector,
    output logic                                  m_too_long
);

    localparam int AW  = csim_pkg::ACC_WIDTH;
    localparam int PW  = csim_pkg::PROD_WIDTH;
    localparam int RW  = csim_pkg::ROOT_WIDTH;
    localparam int NW  = csim_pkg::NUM_WIDTH;
    localparam int SW  = csim_pkg::SIM_WIDTH;
    localparam int CW  = $clog2(MAX_LEN + 1);
    localparam logic [CW-1:0] LEN_LIMIT = CW'(MAX_LEN);
    localparam logic [AW-1:0] BIT_INIT  = AW'(1) << (AW - 2);
    localparam logic [NW-1:0] Q_POS_MAX = NW'((1 << (SW - 1)) - 1);
    localparam logic [NW-1:0] Q_NEG_MAX = NW'(1 << (SW - 1));

    // Configuration and accumulators.
    logic [csim_pkg::CFG_WIDTH-1:0] min_sum_sq_reg;
    logic [AW-1:0] dot_reg, sqa_reg, sqb_reg;
    logic [AW-1:0] dot_next, sqa_next, sqb_next;
    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic signed [PW-1:0] prod_ab, prod_aa, prod_bb;
    logic          room;

    // Work registers for the final computation.
    logic [AW-1:0] va_reg, vb_reg, ra_reg, rb_reg, bit_reg;
    logic [AW-1:0] cand_a, cand_b;
    logic [NW-1:0] num_reg, q_reg;
    logic [AW:0]   rem_reg, rem_shift;
    logic [AW-1:0] den_reg;
    logic          neg_reg, zero_reg, long_reg;
    logic          zero_next;
    logic [AW-1:0] mag_next;
    logic [AW-1:0] min_ext;
    logic [SW-1:0] sim_calc;

    // Element products and the length guard.
    assign prod_ab = s_elem_a * s_elem_b;
    assign prod_aa = s_elem_a * s_elem_a;
    assign prod_bb = s_elem_b * s_elem_b;
    assign room    = (count_reg < LEN_LIMIT);

    always_comb begin
        dot_next   = dot_reg;
        sqa_next   = sqa_reg;
        sqb_next   = sqb_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (room) begin
            dot_next   = dot_reg + AW'(prod_ab);
            sqa_next   = sqa_reg + AW'(prod_aa);
            sqb_next   = sqb_reg + AW'(prod_bb);
            count_next = count_reg + 1'b1;
        end else begin
            ovf_next = 1'b1;
        end
    end

    // Zero-vector test and dot product magnitude on the last pair.
    assign min_ext   = AW'(min_sum_sq_reg);
    assign zero_next = (sqa_next <= min_ext) || (sqb_next <= min_ext);
    assign mag_next  = dot_next[AW-1] ? (~dot_next + 1'b1) : dot_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_sum_sq_reg <= '0;
            dot_reg        <= '0;
            sqa_reg        <= '0;
            sqb_reg        <= '0;
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                min_sum_sq_reg <= cfg_wr_data;
            end
            if (cmd.load_work) begin
                dot_reg   <= '0;
                sqa_reg   <= '0;
                sqb_reg   <= '0;
                count_reg <= '0;
                ovf_reg   <= 1'b0;
            end else if (cmd.acc_en) begin
                dot_reg   <= dot_next;
                sqa_reg   <= sqa_next;
                sqb_reg   <= sqb_next;
                count_reg <= count_next;
                ovf_reg   <= ovf_next;
            end
        end
    end

    assign stat.special = zero_reg | long_reg;

    // Root candidates and the shifted divider remainder.
    assign cand_a    = ra_reg + bit_reg;
    assign cand_b    = rb_reg + bit_reg;
    assign rem_shift = {rem_reg[AW-1:0], num_reg[NW-1]};

    // Work registers: bitwise square roots, root product and restoring divide.
    always_ff @(posedge aclk) begin
        if (cmd.load_work) begin
            va_reg   <= sqa_next;
            vb_reg   <= sqb_next;
            ra_reg   <= '0;
            rb_reg   <= '0;
            bit_reg  <= BIT_INIT;
            num_reg  <= {mag_next, {csim_pkg::FRAC_BITS{1'b0}}};
            rem_reg  <= '0;
            q_reg    <= '0;
            neg_reg  <= dot_next[AW-1];
            long_reg <= ovf_next;
            zero_reg <= ~ovf_next & zero_next;
        end
        if (cmd.sqrt_step) begin
            if (va_reg >= cand_a) begin
                va_reg <= va_reg - cand_a;
                ra_reg <= (ra_reg >> 1) + bit_reg;
            end else begin
                ra_reg <= ra_reg >> 1;
            end
            if (vb_reg >= cand_b) begin
                vb_reg <= vb_reg - cand_b;
                rb_reg <= (rb_reg >> 1) + bit_reg;
            end else begin
                rb_reg <= rb_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
        if (cmd.mul_en) begin
            den_reg <= ra_reg[RW-1:0] * rb_reg[RW-1:0];
        end
        if (cmd.div_step) begin
            num_reg <= num_reg << 1;
            if (rem_shift >= {1'b0, den_reg}) begin
                rem_reg <= rem_shift - {1'b0, den_reg};
                q_reg   <= {q_reg[NW-2:0], 1'b1};
            end else begin
                rem_reg <= rem_shift;
                q_reg   <= {q_reg[NW-2:0], 1'b0};
            end
        end
    end

    // Saturate the quotient to Q1.15 and apply the sign.
    always_comb begin
        if (long_reg || zero_reg) begin
            sim_calc = '0;
        end else if (neg_reg) begin
            sim_calc = (q_reg > Q_NEG_MAX) ? ~Q_NEG_MAX[SW-1:0] + 1'b1
                                           : ~q_reg[SW-1:0] + 1'b1;
        end else begin
            sim_calc = (q_reg > Q_POS_MAX) ? Q_POS_MAX[SW-1:0] : q_reg[SW-1:0];
        end
    end

    // Result register toward the output channel.
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_similarity  <= sim_calc;
            m_zero_vector <= zero_reg;
            m_too_long    <= long_reg;
        end
    end

endmodule

// ----- sv/cosine_similarity_stream_top.sv -----
// Top level of the streaming cosine similarity block.
// Depends on csim_pkg, csim_ctrl and csim_dp.
//
// Usage: element pairs arrive on the s_ channel, one transfer per cycle while
// s_ready is high. Each pair, up to MAX_LEN of them, is multiplied and added
// into the dot product and the two squared lengths in the cycle it is
// accepted. The pair marked by s_last_element closes the vectors; s_ready
// then drops while both integer square roots run (one root bit per step,
// one shared step command), the roots are multiplied and a restoring
// divider produces one quotient bit per cycle. The result then goes to the
// m_ channel; for a zero vector or an over-long one the roots, the product
// and the divide are skipped. The result sits in an output register, so a
// stalled receiver only holds the block once a second result is finished
// while the first still waits. Reset clears the sums, the count, the
// threshold register and the output valid. cfg_wr_en writes the zero
// threshold; write it only while idle.
module cosine_similarity_stream_top #(
    parameter int MAX_LEN = csim_pkg::DEF_MAX_LEN
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_wr_en,
    input  logic [csim_pkg::CFG_WIDTH-1:0]         cfg_wr_data,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [csim_pkg::ELEM_WIDTH-1:0] s_elem_a,
    input  logic signed [csim_pkg::ELEM_WIDTH-1:0] s_elem_b,
    input  logic                                   s_last_element,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [csim_pkg::SIM_WIDTH-1:0]  m_similarity,
    output logic                                   m_zero_vector,
    output logic                                   m_too_long
);

    csim_pkg::csim_cmd_t  cmd;
    csim_pkg::csim_stat_t stat;

    // Sequencer for accumulate, root, multiply, divide and output.
    csim_ctrl u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_last_element (s_last_element),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .stat           (stat),
        .cmd            (cmd)
    );

    // Arithmetic and result registers.
    csim_dp #(
        .MAX_LEN (MAX_LEN)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_elem_a      (s_elem_a),
        .s_elem_b      (s_elem_b),
        .cmd           (cmd),
        .stat          (stat),
        .m_similarity  (m_similarity),
        .m_zero_vector (m_zero_vector),
        .m_too_long    (m_too_long)
    );

endmodule

// ----- sv/csim_checker.sv -----
// Port-level checks for the cosine similarity block, bound to the top level.
// Depends on cosine_similarity_stream_top's port list only.
module csim_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [15:0] m_similarity,
    input logic        m_zero_vector,
    input logic        m_too_long
);

    // A stalled result keeps its value.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_similarity))
        else $error("result changed while stalled");

    // The two flags never come together.
    a_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_zero_vector && m_too_long))
        else $error("zero and too-long flags both set");

    // A flagged result carries zero similarity.
    a_zero_sim: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_zero_vector || m_too_long) |-> m_similarity == 16'd0)
        else $error("flagged result with nonzero similarity");

    // Reset empties the output register.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind cosine_similarity_stream_top csim_checker u_csim_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_similarity  (m_similarity),
    .m_zero_vector (m_zero_vector),
    .m_too_long    (m_too_long)
);
